>>> rtl/u2d_pkg.sv
// u2d_pkg: shared types and constants for the 64-bit binary to decimal ASCII converter.
// Used by u2d_cell and u64_to_decimal_ascii; depends on nothing.
package u2d_pkg;

  localparam int unsigned VALUE_BITS = 64;   // width of the converted number
  localparam int unsigned MAX_DIGITS = 20;   // number of BCD cells / most digits out
  localparam int unsigned IN_BITS    = 64;   // width of the value port
  localparam int unsigned DIGIT_BITS = 4;    // one BCD digit
  localparam int unsigned CHAR_BITS  = 6;    // ASCII digit field width

  localparam int unsigned BIT_CNT_W  = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam int unsigned REM_W      = $clog2(MAX_DIGITS + 1);

  localparam logic [DIGIT_BITS-1:0] BCD_ADJ_MIN = 4'd5;  // add-3 threshold
  localparam logic [DIGIT_BITS-1:0] BCD_ADJ     = 4'd3;
  localparam logic [CHAR_BITS-1:0]  ASCII_ZERO  = 6'd48;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_e;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic clear;  // zero the digit
    logic conv;   // double-dabble step: adjust, shift left, take carry from below
    logic emit;   // shift digits up one cell toward the output end
  } cell_ctl_t;

endpackage

>>> rtl/u2d_cell.sv
// u2d_cell: one BCD digit of the double-dabble chain.
// Depends on u2d_pkg (cell_ctl_t, digit constants).
module u2d_cell (
  input  logic                               clk_i,
  input  u2d_pkg::cell_ctl_t                 ctl_i,
  input  logic                               carry_i,  // bit from the cell below
  input  logic [u2d_pkg::DIGIT_BITS-1:0]     digit_i,  // digit of the cell below
  output logic                               carry_o,  // bit to the cell above
  output logic [u2d_pkg::DIGIT_BITS-1:0]     digit_o
);

  logic [u2d_pkg::DIGIT_BITS-1:0] digit_q, digit_d;
  logic [u2d_pkg::DIGIT_BITS-1:0] adj;

  // add 3 when the digit is 5 or more, so the shift carries into the next decade
  always_comb begin
    adj = (digit_q >= u2d_pkg::BCD_ADJ_MIN) ? (digit_q + u2d_pkg::BCD_ADJ) : digit_q;
  end

  assign carry_o = adj[u2d_pkg::DIGIT_BITS-1];
  assign digit_o = digit_q;

  always_comb begin
    priority if (ctl_i.clear) begin
      digit_d = '0;
    end else if (ctl_i.conv) begin
      digit_d = {adj[u2d_pkg::DIGIT_BITS-2:0], carry_i};
    end else if (ctl_i.emit) begin
      digit_d = digit_i;
    end else begin
      digit_d = digit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

endmodule

>>> rtl/u64_to_decimal_ascii.sv
// u64_to_decimal_ascii: top level, unsigned binary to decimal ASCII digit stream.
// Depends on u2d_pkg and u2d_cell.
//
// Each accepted value is converted by a chain of MAX_DIGITS BCD cells running
// shift-and-add-3 (double dabble): one value bit enters the chain per cycle until
// all VALUE_BITS bits are in. The chain then shifts its digits toward the output end
// one cell per cycle, holding while a digit to be sent waits on a stalled output;
// leading zero digits are dropped in that pass without a transfer, every other digit
// is a transfer of one ASCII character, most significant first, with last_digit_o
// high on the final one. Zero gives a single '0'. The next value is accepted as soon
// as the chain has been emptied, even while the final character still sits in the
// output register. If a number had more than MAX_DIGITS digits, only the low
// MAX_DIGITS digits would come out.
module u64_to_decimal_ascii (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input channel
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [u2d_pkg::IN_BITS-1:0]         value_i,
  // output channel
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [u2d_pkg::CHAR_BITS-1:0]       digit_char_o,
  output logic                                last_digit_o
);

  localparam int unsigned VB = u2d_pkg::VALUE_BITS;
  localparam int unsigned ND = u2d_pkg::MAX_DIGITS;

  u2d_pkg::state_e                     state_q, state_d;
  logic [VB-1:0]                       val_q, val_d;       // value shift register
  logic [u2d_pkg::BIT_CNT_W-1:0]       bit_cnt_q, bit_cnt_d;
  logic [u2d_pkg::REM_W-1:0]           rem_q, rem_d;       // cells left to emit
  logic                                lead_q, lead_d;     // still in leading zeros
  logic                                out_valid_q, out_valid_d;
  logic [u2d_pkg::CHAR_BITS-1:0]       char_q, char_d;
  logic                                last_q, last_d;

  u2d_pkg::cell_ctl_t                  ctl;
  logic [ND-1:0]                       carry_in;
  logic [ND-1:0]                       carry_out;
  logic [u2d_pkg::DIGIT_BITS-1:0]      digit_in  [ND];
  logic [u2d_pkg::DIGIT_BITS-1:0]      digit_out [ND];
  logic [u2d_pkg::DIGIT_BITS-1:0]      top_digit;

  // ---------------------------------------------------------------------------
  // Cell chain: cell 0 is the least significant digit. During conversion bits
  // ripple upward through carries; during emission digits move up one cell.
  // ---------------------------------------------------------------------------
  genvar gi;
  generate
    for (gi = 0; gi < ND; gi++) begin : g_cell
      if (gi == 0) begin : g_bottom
        assign carry_in[gi] = val_q[VB-1];
        assign digit_in[gi] = '0;
      end else begin : g_upper
        assign carry_in[gi] = carry_out[gi-1];
        assign digit_in[gi] = digit_out[gi-1];
      end

      u2d_cell u_cell (
        .clk_i   (clk_i),
        .ctl_i   (ctl),
        .carry_i (carry_in[gi]),
        .digit_i (digit_in[gi]),
        .carry_o (carry_out[gi]),
        .digit_o (digit_out[gi])
      );
    end
  endgenerate

  // the carry out of the top cell is a multiple of 10^MAX_DIGITS; it is dropped
  assign top_digit = digit_out[ND-1];

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= u2d_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      bit_cnt_q   <= '0;
      rem_q       <= '0;
      lead_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      bit_cnt_q   <= bit_cnt_d;
      rem_q       <= rem_d;
      lead_q      <= lead_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  always_comb begin
    state_d     = state_q;
    val_d       = val_q;
    bit_cnt_d   = bit_cnt_q;
    rem_d       = rem_q;
    lead_d      = lead_q;
    out_valid_d = out_valid_q && !out_ready_i;
    char_d      = char_q;
    last_d      = last_q;
    ctl         = '0;
    in_ready_o  = 1'b0;

    unique case (state_q)
      u2d_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl.clear = 1'b1;
          val_d     = value_i[VB-1:0];   // bits above VALUE_BITS ignored
          bit_cnt_d = '0;
          state_d   = u2d_pkg::ST_CONV;
        end
      end

      u2d_pkg::ST_CONV: begin
        ctl.conv  = 1'b1;
        val_d     = val_q << 1;
        bit_cnt_d = bit_cnt_q + 1'b1;
        if (bit_cnt_q == u2d_pkg::BIT_CNT_W'(VB - 1)) begin
          rem_d   = u2d_pkg::REM_W'(ND);
          lead_d  = 1'b1;
          state_d = u2d_pkg::ST_EMIT;
        end
      end

      u2d_pkg::ST_EMIT: begin
        if (lead_q && (top_digit == '0) && (rem_q != u2d_pkg::REM_W'(1))) begin
          // leading zero: drop it, no transfer
          ctl.emit = 1'b1;
          rem_d    = rem_q - 1'b1;
        end else if (!out_valid_q || out_ready_i) begin
          ctl.emit    = 1'b1;
          rem_d       = rem_q - 1'b1;
          lead_d      = 1'b0;
          out_valid_d = 1'b1;
          char_d      = u2d_pkg::ASCII_ZERO
                        + {{(u2d_pkg::CHAR_BITS - u2d_pkg::DIGIT_BITS){1'b0}}, top_digit};
          last_d      = (rem_q == u2d_pkg::REM_W'(1));
          if (rem_q == u2d_pkg::REM_W'(1)) begin
            state_d = u2d_pkg::ST_IDLE;
          end
        end
      end

      default: begin
        state_d = u2d_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign digit_char_o = char_q;
  assign last_digit_o = last_q;

endmodule

>>> bench/tb_u64_to_decimal_ascii.sv
// tb_u64_to_decimal_ascii: self-checking testbench for the binary to decimal ASCII converter.
// Feeds corner and random 64-bit values, predicts the digit stream and checks every transfer.
// Depends on u2d_pkg and the u64_to_decimal_ascii RTL.

localparam int unsigned DECIMAL_BASE = 10;

typedef struct packed {
  logic [u2d_pkg::CHAR_BITS-1:0] digit_char;
  logic                          last_digit;
} decimal_char_t;

// Holds the characters still owed by the block, oldest first.
class DecimalTextScoreboard;
  decimal_char_t expected_chars[$];
  int unsigned   mismatches;
  int unsigned   numbers_done;
  int unsigned   chars_checked;

  function new();
    mismatches    = 0;
    numbers_done  = 0;
    chars_checked = 0;
  endfunction

  // Accepted value: queue its decimal text, most significant digit first.
  function void note_value(input logic [u2d_pkg::IN_BITS-1:0] value);
    logic [63:0]   number;
    logic [3:0]    digits [u2d_pkg::MAX_DIGITS];
    int            count;
    decimal_char_t item;
    number = 64'(value) & ({64{1'b1}} >> (64 - u2d_pkg::VALUE_BITS));
    count  = 0;
    // least significant first; digits beyond MAX_DIGITS are dropped at the top
    do begin
      digits[count] = 4'(number % DECIMAL_BASE);
      number        = number / DECIMAL_BASE;
      count++;
    end while (number != 0 && count < u2d_pkg::MAX_DIGITS);
    for (int k = 0; k < count; k++) begin
      item.digit_char = u2d_pkg::ASCII_ZERO + u2d_pkg::CHAR_BITS'(digits[count - 1 - k]);
      item.last_digit = (k == count - 1);
      expected_chars.push_back(item);
    end
  endfunction

  function void check_char(input logic [u2d_pkg::CHAR_BITS-1:0] digit_char,
                           input logic last_digit);
    decimal_char_t want;
    if (expected_chars.size() == 0) begin
      $error("digit_char %0d (last_digit %0b) arrived with nothing pending",
             digit_char, last_digit);
      mismatches++;
      return;
    end
    want = expected_chars.pop_front();
    if (digit_char !== want.digit_char) begin
      $error("digit_char: expected %0d, got %0d", want.digit_char, digit_char);
      mismatches++;
    end
    if (last_digit !== want.last_digit) begin
      $error("last_digit: expected %0b, got %0b", want.last_digit, last_digit);
      mismatches++;
    end
    chars_checked++;
    if (want.last_digit) numbers_done++;
  endfunction
endclass

module tb_u64_to_decimal_ascii;

  localparam int CLK_PERIOD      = 10;
  localparam int RESET_CYCLES    = 5;
  localparam int RANDOM_ITEMS    = 200;
  localparam int IDLE_PERCENT    = 32;
  // random items in this window run with both sides idle-free
  localparam int CALM_FIRST      = 100;
  localparam int CALM_LAST       = 160;
  // settle time after the last character: long enough for a whole unstalled item, plus a margin
  localparam int DRAIN_CYCLES    = 1 + u2d_pkg::VALUE_BITS + u2d_pkg::MAX_DIGITS + 20;
  // longest correct stretch without a transfer: an input gap, the conversion,
  // up to 19 dropped leading zeros and any output stall
  localparam int WATCHDOG_CYCLES = 4000;

  // Corners: zero, single digits, carries across every decade boundary of interest,
  // the 19/20 digit border, the top of the range and alternating bit patterns.
  localparam logic [u2d_pkg::IN_BITS-1:0] CORNER_VALUES [20] = '{
    64'd0,
    64'd1,
    64'd9,
    64'd10,
    64'd19,
    64'd100,
    64'd909,
    64'd4294967295,
    64'd4294967296,
    64'd999999999999999999,
    64'd1000000000000000000,
    64'd9999999999999999999,
    64'd10000000000000000000,
    64'd12345678901234567890,
    64'h7FFF_FFFF_FFFF_FFFF,
    64'h8000_0000_0000_0000,
    64'hAAAA_AAAA_AAAA_AAAA,
    64'h5555_5555_5555_5555,
    64'd18446744073709551610,
    64'hFFFF_FFFF_FFFF_FFFF
  };

  logic                            clk_i       = 1'b0;
  logic                            rst_ni      = 1'b0;
  logic                            in_valid_i  = 1'b0;
  logic                            in_ready_o;
  logic [u2d_pkg::IN_BITS-1:0]     value_i     = '0;
  logic                            out_valid_o;
  logic                            out_ready_i = 1'b0;
  logic [u2d_pkg::CHAR_BITS-1:0]   digit_char_o;
  logic                            last_digit_o;

  // set during the idle-free window, read by both the sender and the receiver
  logic               calm        = 1'b0;
  int                 idle_cycles = 0;

  DecimalTextScoreboard board = new();

  u64_to_decimal_ascii u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .digit_char_o (digit_char_o),
    .last_digit_o (last_digit_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Receiver: ready drops at random, so stalls land on any character of a number,
  // including the flagged last one that sits in the output register.
  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(99) >= IDLE_PERCENT);
  end

  // Output monitor: values seen here are the ones from before this edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) board.check_char(digit_char_o, last_digit_o);
  end

  // Mix of shapes: raw 64-bit patterns, numbers of a chosen digit count with extra
  // inner zeros, powers of ten and their neighbors, and small values.
  function automatic logic [u2d_pkg::IN_BITS-1:0] random_value();
    logic [63:0] number;
    logic [63:0] scale;
    int          ndigits;
    number = '0;
    scale  = 64'd1;
    case ($urandom_range(9))
      0, 1, 2, 3: number = {$urandom, $urandom};
      8: begin
        repeat ($urandom_range(19)) scale = scale * DECIMAL_BASE;
        number = scale + 64'($urandom_range(2)) - 64'd1;
      end
      9: number = 64'($urandom_range(20));
      default: begin
        ndigits = $urandom_range(1, 20);
        if (ndigits == 20) begin
          // 20 digits only exist from 10^19 up
          do number = {$urandom, $urandom}; while (number < 64'd10000000000000000000);
        end else begin
          number = 64'($urandom_range(1, 9));
          repeat (ndigits - 1) begin
            number = number * DECIMAL_BASE
                   + 64'(($urandom_range(3) == 0) ? 0 : $urandom_range(9));
          end
        end
      end
    endcase
    return number;
  endfunction

  // One input transfer. Valid holds with a fixed value until the block takes it;
  // a random gap with valid low may come first.
  task automatic send_value(input logic [u2d_pkg::IN_BITS-1:0] value);
    if (!calm) begin
      while ($urandom_range(99) < IDLE_PERCENT) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    value_i    <= value;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_value(value);
  endtask

  // Watchdog: any transfer on either side resets the count.
  initial begin
    while (idle_cycles < WATCHDOG_CYCLES) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("timeout: no transfer for %0d cycles", WATCHDOG_CYCLES);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (CORNER_VALUES[i]) send_value(CORNER_VALUES[i]);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      calm <= (i >= CALM_FIRST && i < CALM_LAST);
      send_value(random_value());
    end
    in_valid_i <= 1'b0;

    // wait for the text of every number, then watch for anything extra
    while (board.expected_chars.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("converted %0d numbers (%0d corner, %0d random), %0d digit characters checked",
             board.numbers_done, $size(CORNER_VALUES), RANDOM_ITEMS, board.chars_checked);
    $display("%0d field mismatches, %0d characters still owed",
             board.mismatches, board.expected_chars.size());
    if (board.mismatches == 0 && board.expected_chars.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
